>>> rtl/assert_macros.svh
// Assertion macros shared by the trickle timer RTL.
// Included by modules that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/tat_pkg.sv
// Package for the trickle advertisement timer: beat structs, event codes,
// configuration register indexes and reset values. No dependencies.
`default_nettype none

package tat_pkg;

   localparam int unsigned EXP_W   = 5;
   localparam int unsigned CNT_W   = 32;
   localparam int unsigned RND_W   = 31;
   localparam int unsigned HEARD_W = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [EXP_W-1:0]   EXP_CAP = 5'd31;
   localparam logic [HEARD_W-1:0] HEARD_MAX = 8'd255;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_RESET = 2'd1,
      FUNC_HEARD = 2'd2,
      FUNC_STOP  = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_INTERVAL_EXP = 2'd0,
      CSR_MAX_DOUBLINGS    = 2'd1,
      CSR_REDUNDANCY_LIMIT = 2'd2,
      CSR_LEAF_ONLY        = 2'd3
   } csr_index_type;

   localparam logic [EXP_W-1:0]   RST_MIN_INTERVAL_EXP = 5'd12;
   localparam logic [EXP_W-1:0]   RST_MAX_DOUBLINGS    = 5'd8;
   localparam logic [HEARD_W-1:0] RST_REDUNDANCY_LIMIT = 8'd10;
   localparam logic               RST_LEAF_ONLY        = 1'b0;

   typedef struct packed {
      func_type         func;
      logic             ready_to_advertise;
      logic             is_root;
      logic [RND_W-1:0] random_value;
   } req_type;

   typedef struct packed {
      logic             send_advert;
      logic [EXP_W-1:0] interval_exp;
      logic             timer_armed;
   } rsp_type;

   typedef struct packed {
      logic [EXP_W-1:0]   min_interval_exp;
      logic [EXP_W-1:0]   max_doublings;
      logic [HEARD_W-1:0] redundancy_limit;
      logic               leaf_only;
   } cfg_type;

endpackage

`default_nettype wire

>>> rtl/tat_csr.sv
// Configuration registers of the trickle timer, written through a plain
// write port. Depends on tat_pkg.
`default_nettype none

module tat_csr (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_write_en,
   input  wire [tat_pkg::CSR_IDX_W-1:0]         csr_addr,
   input  wire [tat_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output tat_pkg::cfg_type                     cfg
);
   import tat_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_addr))
            CSR_MIN_INTERVAL_EXP: cfg_in.min_interval_exp = csr_wdata[EXP_W-1:0];
            CSR_MAX_DOUBLINGS:    cfg_in.max_doublings    = csr_wdata[EXP_W-1:0];
            CSR_REDUNDANCY_LIMIT: cfg_in.redundancy_limit = csr_wdata[HEARD_W-1:0];
            CSR_LEAF_ONLY:        cfg_in.leaf_only        = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_interval_exp <= RST_MIN_INTERVAL_EXP;
         cfg_ff.max_doublings    <= RST_MAX_DOUBLINGS;
         cfg_ff.redundancy_limit <= RST_REDUNDANCY_LIMIT;
         cfg_ff.leaf_only        <= RST_LEAF_ONLY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/tat_engine.sv
// Timer state and the single-pass event logic of the trickle timer.
// Depends on tat_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module tat_engine (
   input  wire              clock,
   input  wire              reset,
   input  wire              advance,
   input  tat_pkg::req_type req,
   input  tat_pkg::cfg_type cfg,
   output tat_pkg::rsp_type rsp
);
   import tat_pkg::*;

   logic [EXP_W-1:0]   cur_exp_ff, cur_exp_in;
   logic [CNT_W-1:0]   remaining_ff, remaining_in;
   logic [CNT_W-1:0]   rest_ff, rest_in;
   logic               send_phase_ff, send_phase_in;
   logic [HEARD_W-1:0] heard_ff, heard_in;
   logic               armed_ff, armed_in;

   logic               reset_ok;
   logic               can_grow;
   logic [EXP_W-1:0]   grown_exp;
   logic [EXP_W-1:0]   start_exp;
   logic [CNT_W-1:0]   whole;
   logic [CNT_W-1:0]   half;
   logic [CNT_W-1:0]   draw;
   logic               send;

   assign reset_ok = req.ready_to_advertise && !cfg.leaf_only &&
                     ((cur_exp_ff == '0) || (cur_exp_ff > cfg.min_interval_exp));
   assign can_grow = ({1'b0, cur_exp_ff} <
                      ({1'b0, cfg.min_interval_exp} + {1'b0, cfg.max_doublings})) &&
                     (cur_exp_ff < EXP_CAP);
   assign grown_exp = can_grow ? cur_exp_ff + 5'd1 : cur_exp_ff;
   assign start_exp = (req.func == FUNC_RESET) ? cfg.min_interval_exp : grown_exp;

   // The draw lies in the upper half of the interval; the random bits fill
   // the lower half-interval positions.
   assign whole = {{(CNT_W-1){1'b0}}, 1'b1} << start_exp;
   assign half  = whole >> 1;
   assign draw  = (half == '0) ? '0 :
                  (half | ({1'b0, req.random_value} & (half - {{(CNT_W-1){1'b0}}, 1'b1})));

   always_comb begin
      cur_exp_in    = cur_exp_ff;
      remaining_in  = remaining_ff;
      rest_in       = rest_ff;
      send_phase_in = send_phase_ff;
      heard_in      = heard_ff;
      armed_in      = armed_ff;
      send          = 1'b0;
      case (req.func)
         FUNC_TICK: begin
            if (armed_ff) begin
               if (remaining_ff <= {{(CNT_W-1){1'b0}}, 1'b1}) begin
                  remaining_in = '0;
                  armed_in     = 1'b0;
                  if (req.ready_to_advertise) begin
                     if (send_phase_ff) begin
                        send = req.is_root || (cfg.redundancy_limit == '0) ||
                               (heard_ff < cfg.redundancy_limit);
                        send_phase_in = 1'b0;
                        remaining_in  = rest_ff;
                        armed_in      = 1'b1;
                     end else begin
                        cur_exp_in    = grown_exp;
                        rest_in       = whole - draw;
                        send_phase_in = 1'b1;
                        heard_in      = '0;
                        remaining_in  = draw;
                        armed_in      = 1'b1;
                     end
                  end
               end else begin
                  remaining_in = remaining_ff - {{(CNT_W-1){1'b0}}, 1'b1};
               end
            end
         end
         FUNC_RESET: begin
            if (reset_ok) begin
               cur_exp_in    = cfg.min_interval_exp;
               rest_in       = whole - draw;
               send_phase_in = 1'b1;
               heard_in      = '0;
               remaining_in  = draw;
               armed_in      = 1'b1;
            end
         end
         FUNC_HEARD: begin
            if (heard_ff < HEARD_MAX) begin
               heard_in = heard_ff + 8'd1;
            end
         end
         default: begin
            armed_in     = 1'b0;
            remaining_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_exp_ff    <= '0;
         remaining_ff  <= '0;
         rest_ff       <= '0;
         send_phase_ff <= 1'b0;
         heard_ff      <= '0;
         armed_ff      <= 1'b0;
      end else if (advance) begin
         cur_exp_ff    <= cur_exp_in;
         remaining_ff  <= remaining_in;
         rest_ff       <= rest_in;
         send_phase_ff <= send_phase_in;
         heard_ff      <= heard_in;
         armed_ff      <= armed_in;
      end
   end

   assign rsp.send_advert  = send;
   assign rsp.interval_exp = cur_exp_in;
   assign rsp.timer_armed  = armed_in;

   // A stopped countdown always holds zero.
   `ASSERT_IMPL(a_idle_count_zero, clock, reset, !armed_ff, remaining_ff == '0)
   // Only a tick can trigger an advertisement.
   `ASSERT_IMPL(a_send_on_tick, clock, reset, advance && send, req.func == FUNC_TICK)

endmodule

`default_nettype wire

>>> rtl/trickle_advertisement_timer.sv
// Path: a beat accepted into the input register moves into the result register
// when advance is high. Throughput: one beat per cycle while rsp_ready does not
// stall the result register, set by the single-pass event logic between the two.
// Reset is synchronous and active high; it clears the timer state, empties both
// registers and loads the configuration reset values.
// Top level of the trickle timer. Depends on tat_pkg, tat_csr, tat_engine and
// assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module trickle_advertisement_timer (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  tat_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output tat_pkg::rsp_type              rsp_data,
   input  wire                           csr_write_en,
   input  wire [tat_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  wire [tat_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tat_pkg::*;

   cfg_type cfg;
   req_type in_data_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type rsp_next;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    advance;
   logic    req_take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   tat_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   tat_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A beat waiting in the input register is never dropped.
   `ASSERT_NEXT(a_in_held, clock, reset, in_valid_ff && !advance, in_valid_ff)
   // An advertisement always leaves the countdown running for the rest.
   `ASSERT_IMPL(a_send_armed, clock, reset, rsp_valid_ff && rsp_data_ff.send_advert, rsp_data_ff.timer_armed)

endmodule

`default_nettype wire
